// ===== rtl/irdist_pkg.sv =====
package irdist_pkg;

  localparam int ADC_BITS   = 12;
  localparam int THR_W      = 12;
  localparam int DIST_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FAR_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_DISTANCE   = 2'd3;

  localparam logic [THR_W-1:0]  FAR_THRESHOLD_RST  = 12'd434;
  localparam logic [THR_W-1:0]  NEAR_THRESHOLD_RST = 12'd3114;
  localparam logic [DIST_W-1:0] MIN_DISTANCE_RST   = 16'd6400;
  localparam logic [DIST_W-1:0] FAR_DISTANCE_RST   = 16'd38400;
  localparam logic [DIST_W-1:0] AVERAGE_RST        = 16'd38400;

  // 77285.5 cm * 100 * 256 over (100 * raw - 2482)
  localparam logic [31:0]       CURVE_NUM = 32'd1978508800;
  localparam logic [11:0]       CURVE_OFS = 12'd2482;
  localparam logic [DIST_W-1:0] CURVE_HI  = CURVE_NUM[31:16];
  localparam logic [DIST_W-1:0] CURVE_LO  = CURVE_NUM[15:0];
  localparam logic [3:0]        EMA_DIV   = 4'd5;

  typedef struct packed {
    logic [ADC_BITS-1:0] sample_raw;
    logic                conversion_ok;
  } sample_t;

  typedef struct packed {
    logic [DIST_W-1:0] instant_distance;
    logic [DIST_W-1:0] smoothed_distance;
  } result_t;

endpackage

// ===== rtl/ir_range_to_distance_ema_unit.sv =====
// datapath: an accepted sample passes the 16-step bit-serial curve divider when the
// inverse curve is evaluated and skips it when a threshold, the curve pole or
// saturation decides, then the 19-step divide-by-five; one sample at a time, the
// next taken once the result register loads, which waits while dist_ready is low
// and a result is still held; reset: thresholds and distances return to defaults,
// filtered distance to 150 cm
module ir_range_to_distance_ema_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                smp_valid,
  output logic                                smp_ready,
  input  irdist_pkg::sample_t                 smp,
  output logic                                dist_valid,
  input  logic                                dist_ready,
  output irdist_pkg::result_t                 distance,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [irdist_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [irdist_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int ADC_W = irdist_pkg::ADC_BITS;
  localparam int THR_W = irdist_pkg::THR_W;
  localparam int DW    = irdist_pkg::DIST_W;
  localparam int CMP_W = (ADC_W > THR_W) ? ADC_W : THR_W;
  localparam int DEN_W = ADC_W + 7;
  localparam int REM_W = DEN_W + 1;
  localparam int SUM_W = DW + 3;
  localparam int CNT_W = $clog2(SUM_W);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_PREP = 5'b00100,
    S_EMA  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t             state;
  logic [THR_W-1:0]   far_th;
  logic [THR_W-1:0]   near_th;
  logic [DW-1:0]      min_dist;
  logic [DW-1:0]      far_dist;
  logic [DW-1:0]      avg;
  logic [CNT_W-1:0]   cnt;
  logic               run_div;
  logic [DW-1:0]      inst;
  logic [DEN_W-1:0]   den;
  logic [DEN_W-1:0]   rem;
  logic [DW-1:0]      quo;
  logic [SUM_W-1:0]   esh;
  logic [2:0]         erem;

  logic [ADC_W-1:0]   s;
  logic [CMP_W-1:0]   s_cmp;
  logic [DEN_W-1:0]   s100;
  logic               pole;
  logic [DEN_W-1:0]   den_in;
  logic               sat;
  logic               accept;
  logic               load_out;
  logic [REM_W-1:0]   trial;
  logic               ge;
  logic [REM_W-1:0]   trial_sub;
  logic [DEN_W-1:0]   rem_next;
  logic [3:0]         etrial;
  logic               ge5;
  logic [2:0]         erem_next;
  logic [DW-1:0]      inst_next;
  logic [SUM_W-1:0]   sum;

  assign cfg_ready = 1'b1;
  assign smp_ready = (state == S_IDLE);
  assign accept    = smp_valid && smp_ready;
  assign load_out  = (state == S_DONE) && (!dist_valid || dist_ready);

  // sample classification at accept
  assign s      = smp.conversion_ok ? smp.sample_raw : '0;
  assign s_cmp  = CMP_W'(s);
  assign s100   = (DEN_W'(s) << 6) + (DEN_W'(s) << 5) + (DEN_W'(s) << 2);
  assign pole   = s100 <= DEN_W'(irdist_pkg::CURVE_OFS);
  assign den_in = s100 - DEN_W'(irdist_pkg::CURVE_OFS);
  assign sat    = den_in <= DEN_W'(irdist_pkg::CURVE_HI);

  // one quotient bit of the curve division per cycle
  assign trial     = {rem, quo[DW-1]};
  assign ge        = trial >= REM_W'(den);
  assign trial_sub = trial - REM_W'(den);
  assign rem_next  = ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];

  // one quotient bit of the divide by five per cycle
  assign etrial    = {erem, esh[SUM_W-1]};
  assign ge5       = etrial >= irdist_pkg::EMA_DIV;
  assign erem_next = ge5 ? 3'(etrial - irdist_pkg::EMA_DIV) : etrial[2:0];

  assign inst_next = !run_div ? inst : ((quo < min_dist) ? min_dist : quo);
  assign sum       = SUM_W'(inst_next) + SUM_W'({avg, 2'b00});

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      dist_valid <= 1'b0;
      far_th     <= irdist_pkg::FAR_THRESHOLD_RST;
      near_th    <= irdist_pkg::NEAR_THRESHOLD_RST;
      min_dist   <= irdist_pkg::MIN_DISTANCE_RST;
      far_dist   <= irdist_pkg::FAR_DISTANCE_RST;
      avg        <= irdist_pkg::AVERAGE_RST;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          irdist_pkg::REG_FAR_THRESHOLD:  far_th   <= cfg_data[THR_W-1:0];
          irdist_pkg::REG_NEAR_THRESHOLD: near_th  <= cfg_data[THR_W-1:0];
          irdist_pkg::REG_MIN_DISTANCE:   min_dist <= cfg_data[DW-1:0];
          irdist_pkg::REG_FAR_DISTANCE:   far_dist <= cfg_data[DW-1:0];
          default: ;
        endcase
      end
      if (load_out) begin
        dist_valid <= 1'b1;
        avg        <= esh[DW-1:0];
      end else if (dist_ready) begin
        dist_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_cmp > CMP_W'(far_th) && s_cmp <= CMP_W'(near_th) && !pole && !sat) begin
              state <= S_DIV;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_DIV: begin
          if (cnt == '0) begin
            state <= S_PREP;
          end
        end
        S_PREP: state <= S_EMA;
        S_EMA: begin
          if (cnt == '0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cnt     <= CNT_W'(DW - 1);
        run_div <= 1'b0;
        den     <= den_in;
        rem     <= DEN_W'(irdist_pkg::CURVE_HI);
        quo     <= irdist_pkg::CURVE_LO;
        if (s_cmp <= CMP_W'(far_th)) begin
          inst <= far_dist;
        end else if (s_cmp > CMP_W'(near_th)) begin
          inst <= min_dist;
        end else if (pole) begin
          inst <= far_dist;
        end else if (sat) begin
          inst <= '1;
        end else begin
          run_div <= 1'b1;
        end
      end
      S_DIV: begin
        rem <= rem_next;
        quo <= {quo[DW-2:0], ge};
        cnt <= cnt - 1'b1;
      end
      S_PREP: begin
        inst <= inst_next;
        esh  <= sum;
        erem <= '0;
        cnt  <= CNT_W'(SUM_W - 1);
      end
      S_EMA: begin
        erem <= erem_next;
        esh  <= {esh[SUM_W-2:0], ge5};
        cnt  <= cnt - 1'b1;
      end
      S_DONE: begin
        if (load_out) begin
          distance.instant_distance  <= inst;
          distance.smoothed_distance <= esh[DW-1:0];
        end
      end
      default: ;
    endcase
  end

  a_single_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !smp_ready)
    else $error("sample taken while busy");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < den)
    else $error("curve remainder out of range");

  a_ema_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_EMA |-> erem < 3'(irdist_pkg::EMA_DIV))
    else $error("average remainder out of range");

  a_ema_dir: assert property (@(posedge clk) disable iff (rst)
    load_out |=> ((distance.smoothed_distance >= $past(avg)) ==
                  (distance.instant_distance >= $past(avg))))
    else $error("average moved away from new distance");

endmodule
